// ===== rtl/core/cif_pkg.sv =====
// Shared types, constants and the kernel coefficient table of the 3x3 image filter.
// No dependencies; the line store, window cell, adder, top level and testbench files import this package.
package cif_pkg;

  // Geometry
  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_HEIGHT     = 4096;
  localparam int DIM_W          = 13;
  localparam int ADDR_W         = $clog2(MAX_WIDTH);

  // Fixed point coefficients
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_ONE       = 1 << COEF_FRAC_BITS;
  localparam int COEF_W         = COEF_FRAC_BITS + 5;   // holds +/- 9.0
  localparam int PROD_W         = COEF_W + 9;           // 9-bit signed sample times coefficient
  localparam int ROW_W          = PROD_W + 2;
  localparam int SUM_W          = PROD_W + 4;

  typedef logic [23:0]               pix_t;   // blue 23:16, green 15:8, red 7:0
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FILTER = 2'd2,
    CFG_COLOR  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FILT_SMOOTH  = 3'd0,
    FILT_BLUR    = 3'd1,
    FILT_SHARPEN = 3'd2,
    FILT_MEAN    = 3'd3,
    FILT_EMBOSS  = 3'd4
  } filt_t;

  // Window taps: row major, row 0 above, column 0 left
  localparam logic [3:0] TAP_ABOVE  = 4'd1;
  localparam logic [3:0] TAP_CENTRE = 4'd4;
  localparam logic [3:0] TAP_BELOW  = 4'd7;

  localparam coef_t K_SM  = coef_t'((COEF_ONE + 4) / 9);
  localparam coef_t K_B1  = coef_t'(COEF_ONE / 16);
  localparam coef_t K_B2  = coef_t'(2 * COEF_ONE / 16);
  localparam coef_t K_B4  = coef_t'(4 * COEF_ONE / 16);
  localparam coef_t K_SE  = coef_t'(-((2 * COEF_ONE + 1) / 3));
  localparam coef_t K_SC  = coef_t'(COEF_ONE + 4 * ((2 * COEF_ONE + 1) / 3));
  localparam coef_t K_MC  = coef_t'(9 * COEF_ONE);
  localparam coef_t K_ONE = coef_t'(COEF_ONE);
  localparam coef_t K_M1  = coef_t'(-COEF_ONE);

  function automatic coef_t kernel_coef(input logic [2:0] sel, input logic [3:0] tap);
    logic  corner;
    logic  centre;
    coef_t k;
    corner = (tap == 4'd0) || (tap == 4'd2) || (tap == 4'd6) || (tap == 4'd8);
    centre = (tap == TAP_CENTRE);
    unique case (sel)
      FILT_SMOOTH:  k = K_SM;
      FILT_BLUR:    k = centre ? K_B4 : (corner ? K_B1 : K_B2);
      FILT_SHARPEN: k = centre ? K_SC : (corner ? '0 : K_SE);
      FILT_MEAN:    k = centre ? K_MC : K_M1;
      FILT_EMBOSS:  k = (tap == TAP_BELOW) ? K_ONE : ((tap == TAP_ABOVE) ? K_M1 : '0);
      default:      k = K_SM;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/cif_in_if.sv =====
// Pixel input channel: valid/ready handshake with kind and RGB payload.
// No dependencies.
interface cif_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, kind, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

// ===== rtl/core/cif_out_if.sv =====
// Filtered pixel output channel: valid/ready handshake with RGB and frame end flag.
// No dependencies.
interface cif_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// ===== rtl/core/cif_line_buf.sv =====
// Two line stores (upper and middle row) with registered reads and write forwarding.
// Depends on cif_pkg.
module cif_line_buf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    wr,
  input  logic [cif_pkg::ADDR_W-1:0] addr,
  input  cif_pkg::pix_t           wdata,
  output cif_pkg::pix_t           up,
  output cif_pkg::pix_t           mid
);
  import cif_pkg::*;

  pix_t              upper_mem  [MAX_WIDTH];
  pix_t              middle_mem [MAX_WIDTH];
  pix_t              up_rd_r;
  pix_t              mid_rd_r;
  pix_t              fwd_val_r;
  logic [ADDR_W-1:0] addr_r;
  logic              pend_r;
  logic              fwd_r;

  // Middle store: read old entry, write new pixel in the same transfer
  always_ff @(posedge clk) begin
    if (en && wr) begin
      mid_rd_r          <= middle_mem[addr];
      middle_mem[addr]  <= wdata;
    end
  end

  // Upper store: old middle entry of the previous item moves up from mid_rd_r
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr) begin
        up_rd_r <= upper_mem[addr];
      end
      if (pend_r) begin
        upper_mem[addr_r] <= mid_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr) begin
      addr_r    <= addr;
      fwd_val_r <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (en) begin
      pend_r <= wr;
      if (wr) begin
        fwd_r <= pend_r && (addr_r == addr);
      end
    end
  end

  // Same column read while its upper write was still pending: take the pending value
  assign up  = fwd_r ? fwd_val_r : up_rd_r;
  assign mid = mid_rd_r;

endmodule

// ===== rtl/core/cif_win_cell.sv =====
// One tap of the 3x3 window: holds a pixel, hands it left, and forms its weighted products.
// Depends on cif_pkg.
module cif_win_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            shift,
  input  cif_pkg::pix_t   pix_in,
  input  logic            use_tap,
  input  cif_pkg::coef_t  coef,
  output cif_pkg::pix_t   pix_out,
  output cif_pkg::prod_t  prod [3]
);
  import cif_pkg::*;

  pix_t  pix_r;
  prod_t prod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (en && shift) begin
      pix_r <= pix_in;
    end
  end

  // Product of each channel, zero when the tap lies on the image border
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (use_tap) begin
          prod_r[ch] <= $signed({1'b0, pix_r[8*ch +: 8]}) * coef;
        end else begin
          prod_r[ch] <= '0;
        end
      end
    end
  end

  assign pix_out = pix_r;
  assign prod    = prod_r;

endmodule

// ===== rtl/core/cif_sum.sv =====
// Sums the nine products of one channel in two registered steps and clamps to 0..255.
// Depends on cif_pkg.
module cif_sum (
  input  logic           clk,
  input  logic           en,
  input  cif_pkg::prod_t prod [9],
  output logic [7:0]     pix_r
);
  import cif_pkg::*;

  logic signed [ROW_W-1:0] row_r [3];
  logic signed [SUM_W-1:0] sum_w;
  logic [7:0]              pix_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        row_r[k] <= ROW_W'(prod[3*k]) + ROW_W'(prod[3*k+1]) + ROW_W'(prod[3*k+2]);
      end
    end
  end

  always_comb begin
    sum_w = SUM_W'(row_r[0]) + SUM_W'(row_r[1]) + SUM_W'(row_r[2]);
    if (sum_w[SUM_W-1]) begin
      pix_nxt = 8'd0;
    end else if (|sum_w[SUM_W-2:COEF_FRAC_BITS+8]) begin
      pix_nxt = 8'hFF;
    end else begin
      pix_nxt = sum_w[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

// ===== rtl/core/conv3x3_image_filter.sv =====
// Top level of the 3x3 image convolution filter: counters, configuration, window chain,
// output register with skid stage. Depends on cif_pkg, cif_in_if, cif_out_if,
// cif_line_buf, cif_win_cell and cif_sum.
//
// The block takes one pixel (or flush tick) per clock while in_ready is high and, once the pipeline is full,
// returns one filtered pixel per clock while the sink is ready. A frame is image_width x image_height
// pixels in raster order followed by image_width+1 flush ticks for the bottom border; the first
// image_width+1 transfers of a frame give no result and every later one gives exactly
// one. Behind the line stores sit five register stages (store read, window, products,
// row sums, clamp) and an output register, which a result passes in that order after the
// transfer that completes it. The rate is set by the two line stores, each a single
// 4096 x 24 memory with one read and one write per cycle. in_ready drops only while the
// one-entry skid stage holds a result that the sink has not taken. Store entries never
// written only feed border taps, which are forced to zero, so the stores need no clearing
// pass after reset. Configuration must be written while no result is outstanding.
module conv3x3_image_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  cif_pkg::cfg_idx_t          cfg_index,
  input  logic [cif_pkg::DIM_W-1:0]  cfg_wdata,
  cif_in_if.sink                     in_ch,
  cif_out_if.source                  out_ch
);
  import cif_pkg::*;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  // Configuration registers
  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;
  logic [2:0]       filter_select_r;
  logic             color_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= DIM_W'(640);
      image_height_r  <= DIM_W'(480);
      filter_select_r <= FILT_SMOOTH;
      color_mode_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  image_width_r   <= cfg_wdata;
        CFG_HEIGHT: image_height_r  <= cfg_wdata;
        CFG_FILTER: filter_select_r <= cfg_wdata[2:0];
        CFG_COLOR:  color_mode_r    <= cfg_wdata[0];
      endcase
    end
  end

  // Pipeline advance: hold everything while the skid stage is occupied
  logic adv;
  logic accept;
  logic skid_valid_r;

  assign adv         = !skid_valid_r;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  // Frame position of the incoming transfer
  logic [DIM_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [DIM_W-1:0] w_eff, h_eff, h_p1;
  logic [DIM_W-1:0] c0, r0, cur_c, cur_r, c_inc;
  logic             wrap, restart, col_nz, res_valid, pix_ok;
  border_t          bord;
  pix_t             in_pix;

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (image_width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width_r;
    end
    if (image_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    h_p1 = h_eff + 1'b1;

    // Column past the row end: move to the next row; past the frame end: restart
    wrap    = (col_r >= w_eff);
    c0      = wrap ? '0 : col_r;
    r0      = wrap ? row_r + 1'b1 : row_r;
    restart = (r0 > h_p1) || ((r0 == h_p1) && (c0 != '0));
    cur_c   = restart ? '0 : c0;
    cur_r   = restart ? '0 : r0;

    // Flush ticks and bottom border rows enter as zero
    pix_ok = !in_ch.kind && (cur_r < h_eff);
    in_pix = '0;
    if (pix_ok) begin
      in_pix[7:0] = in_ch.in_red;
      if (color_mode_r) begin
        in_pix[15:8]  = in_ch.in_green;
        in_pix[23:16] = in_ch.in_blue;
      end
    end

    // Result for the pixel one row up and one column left; at column zero it closes
    // the row before
    col_nz = (cur_c != '0);
    if (col_nz) begin
      res_valid   = (cur_r >= DIM_W'(1)) && (cur_r <= h_eff);
      bord.top    = (cur_r == DIM_W'(1));
      bord.bottom = (cur_r == h_eff);
      bord.left   = (cur_c == DIM_W'(1));
      bord.right  = (cur_c == w_eff);
    end else begin
      res_valid   = (cur_r >= DIM_W'(2)) && (cur_r <= h_p1);
      bord.top    = (cur_r == DIM_W'(2));
      bord.bottom = (cur_r == h_p1);
      bord.left   = (w_eff == DIM_W'(1));
      bord.right  = 1'b1;
    end

    c_inc = cur_c + 1'b1;
    if (cur_r >= h_p1) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = cur_r + 1'b1;
    end else begin
      col_nxt = c_inc;
      row_nxt = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line stores: read at the current column, stage 1 sees the data
  pix_t lb_up, lb_mid;

  cif_line_buf u_line_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .wr    (accept),
    .addr  (cur_c[ADDR_W-1:0]),
    .wdata (in_pix),
    .up    (lb_up),
    .mid   (lb_mid)
  );

  // Stage control
  logic    s1_item_r, s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic    s2_last_r, s3_last_r, s4_last_r, s5_last_r;
  border_t s1_bord_r, s2_bord_r;
  pix_t    s1_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_item_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s1_item_r  <= accept;
      s1_valid_r <= accept && res_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bord_r <= bord;
      s1_data_r <= in_pix;
      s2_bord_r <= s1_bord_r;
      s2_last_r <= s1_bord_r.bottom && s1_bord_r.right;
      s3_last_r <= s2_last_r;
      s4_last_r <= s3_last_r;
      s5_last_r <= s4_last_r;
    end
  end

  // Window: three rows of three cells, each row shifting left on every item
  pix_t  row_src [3];
  pix_t  pix_w   [9];
  prod_t prod_w  [9][3];
  prod_t chan_w  [3][9];
  logic  win_shift;

  assign row_src[0] = lb_up;
  assign row_src[1] = lb_mid;
  assign row_src[2] = s1_data_r;
  assign win_shift  = s1_item_r;

  for (genvar i = 0; i < 9; i++) begin : g_tap
    localparam int ROW = i / 3;
    localparam int COL = i % 3;
    pix_t  tap_in;
    logic  tap_use;
    coef_t tap_coef;

    if (COL == 2) begin : g_feed
      assign tap_in = row_src[ROW];
    end else begin : g_link
      assign tap_in = pix_w[i+1];
    end

    assign tap_use  = !(((ROW == 0) && s2_bord_r.top) || ((ROW == 2) && s2_bord_r.bottom) ||
                        ((COL == 0) && s2_bord_r.left) || ((COL == 2) && s2_bord_r.right));
    assign tap_coef = kernel_coef(filter_select_r, 4'(i));

    cif_win_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .shift   (win_shift),
      .pix_in  (tap_in),
      .use_tap (tap_use),
      .coef    (tap_coef),
      .pix_out (pix_w[i]),
      .prod    (prod_w[i])
    );

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      assign chan_w[ch][i] = prod_w[i][ch];
    end
  end

  // Adder trees and clamp, one per channel
  logic [7:0] res_w [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_sum
    cif_sum u_sum (
      .clk   (clk),
      .en    (adv),
      .prod  (chan_w[ch]),
      .pix_r (res_w[ch])
    );
  end

  // Output register with one-entry skid stage
  logic       res_push;
  logic       out_valid_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_last_r;
  logic [7:0] skid_red_r, skid_green_r, skid_blue_r;
  logic       skid_last_r;
  logic [7:0] res_green, res_blue;

  assign res_push  = adv && s5_valid_r;
  assign res_green = color_mode_r ? res_w[1] : 8'd0;
  assign res_blue  = color_mode_r ? res_w[2] : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_push;
      end
    end else if (res_push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_red_r   <= skid_red_r;
        out_green_r <= skid_green_r;
        out_blue_r  <= skid_blue_r;
        out_last_r  <= skid_last_r;
      end else if (res_push) begin
        out_red_r   <= res_w[0];
        out_green_r <= res_green;
        out_blue_r  <= res_blue;
        out_last_r  <= s5_last_r;
      end
    end else if (res_push) begin
      skid_red_r   <= res_w[0];
      skid_green_r <= res_green;
      skid_blue_r  <= res_blue;
      skid_last_r  <= s5_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_red    = out_red_r;
  assign out_ch.out_green  = out_green_r;
  assign out_ch.out_blue   = out_blue_r;
  assign out_ch.frame_last = out_last_r;

endmodule

// ===== test/cif_tb_pkg.sv =====
// Scoreboard of the 3x3 image filter testbench: a bit-exact predictor of the filtered
// pixel stream and a queue of the pixels still to come out of the block.
// Depends on cif_pkg.
package cif_tb_pkg;
  import cif_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } filtered_pix_t;

  // Geometry as the block uses it: zero reads as one, oversize as the maximum
  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  class filter_scoreboard;
    pix_t             upper_line [MAX_WIDTH];
    pix_t             middle_line[MAX_WIDTH];
    pix_t             window     [9];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [2:0]       filter_reg;
    logic             color_reg;
    filtered_pix_t    pending_pixels[$];
    int unsigned      errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = DIM_W'(640);
      height_reg = DIM_W'(480);
      filter_reg = FILT_SMOOTH;
      color_reg  = 1'b1;
      errors     = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [DIM_W-1:0] val);
      case (idx)
        CFG_WIDTH:  width_reg  = val;
        CFG_HEIGHT: height_reg = val;
        CFG_FILTER: filter_reg = val[2:0];
        CFG_COLOR:  color_reg  = val[0];
      endcase
    endfunction

    // Kernel weight of one tap, 16 fraction bits
    function longint tap_weight(int unsigned tap);
      longint one;
      longint side;
      bit     corner;
      one    = longint'(1) << COEF_FRAC_BITS;
      side   = (2 * one + 1) / 3;
      corner = (tap / 3 != 1) && (tap % 3 != 1);
      case (filter_reg)
        FILT_BLUR:    return (tap == TAP_CENTRE) ? one / 4 : (corner ? one / 16 : one / 8);
        FILT_SHARPEN: return (tap == TAP_CENTRE) ? one + 4 * side : (corner ? 0 : -side);
        FILT_MEAN:    return (tap == TAP_CENTRE) ? 9 * one : -one;
        FILT_EMBOSS:  return (tap == TAP_BELOW) ? one : ((tap == TAP_ABOVE) ? -one : 0);
        default:      return (one + 4) / 9;
      endcase
    endfunction

    function logic [7:0] channel_value(bit [8:0] used, int unsigned shift);
      longint acc;
      longint scaled;
      acc = 0;
      for (int unsigned i = 0; i < 9; i++)
        if (used[i]) acc += longint'(window[i][shift +: 8]) * tap_weight(i);
      if (acc < 0) return 8'd0;
      scaled = acc >>> COEF_FRAC_BITS;
      return (scaled > 255) ? 8'hFF : scaled[7:0];
    endfunction

    // One accepted transfer: advance the window and queue the pixel it completes
    function void note_pixel(logic kind, logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue);
      int unsigned   w, h, c, r, out_row, out_col;
      pix_t          fresh, up, mid;
      bit            produce;
      bit [8:0]      used;
      filtered_pix_t px;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos > h + 1 || (row_pos == h + 1 && col_pos > 0)) begin
        col_pos = 0;
        row_pos = 0;
      end
      c = col_pos;
      r = row_pos;

      fresh = '0;
      if (!kind && r < h) begin
        fresh[7:0] = red;
        if (color_reg) fresh[23:8] = {blue, green};
      end
      up  = upper_line[c];
      mid = middle_line[c];
      for (int i = 0; i < 3; i++) begin
        window[3 * i]     = window[3 * i + 1];
        window[3 * i + 1] = window[3 * i + 2];
      end
      window[2]      = up;
      window[5]      = mid;
      window[8]      = fresh;
      upper_line[c]  = mid;
      middle_line[c] = fresh;

      produce = 1'b0;
      out_row = 0;
      out_col = 0;
      if (c >= 1) begin
        if (r >= 1 && r <= h) begin
          produce = 1'b1;
          out_row = r - 1;
          out_col = c - 1;
        end
      end else if (r >= 2 && r <= h + 1) begin
        produce = 1'b1;
        out_row = r - 2;
        out_col = w - 1;
      end

      if (r >= h + 1) begin
        col_pos = 0;
        row_pos = 0;
      end else begin
        col_pos = c + 1;
        if (col_pos >= w) begin
          col_pos = 0;
          row_pos = r + 1;
        end
      end
      if (!produce) return;

      for (int i = 0; i < 9; i++)
        used[i] = !((i / 3 == 0 && out_row == 0) || (i / 3 == 2 && out_row == h - 1) ||
                    (i % 3 == 0 && out_col == 0) || (i % 3 == 2 && out_col == w - 1));
      px.red   = channel_value(used, 0);
      px.green = color_reg ? channel_value(used, 8) : 8'd0;
      px.blue  = color_reg ? channel_value(used, 16) : 8'd0;
      px.last  = (out_row == h - 1 && out_col == w - 1);
      pending_pixels.push_back(px);
    endfunction

    function void compare_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
    endfunction

    function void check_pixel(filtered_pix_t got);
      filtered_pix_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected pixel, expected none, actual %0d/%0d/%0d last %0d",
                   $time, got.red, got.green, got.blue, got.last);
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
      compare_field("frame_last", want.last, got.last);
    endfunction

    function void close_out();
      if (pending_pixels.size() != 0) begin
        errors += pending_pixels.size();
        $display("%0t: %0d expected pixels never arrived", $time, pending_pixels.size());
      end
    endfunction
  endclass

endpackage

// ===== test/conv3x3_image_filter_tb.sv =====
// Top level testbench of the 3x3 image filter: drives frames through conv3x3_image_filter
// and checks every filtered pixel. Depends on cif_pkg, cif_in_if, cif_out_if and
// cif_tb_pkg.
module conv3x3_image_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cif_pkg::*;
  import cif_tb_pkg::*;

  // Selector value past the last kernel; the block treats it as smooth
  localparam logic [2:0] SEL_UNUSED = 3'd7;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 1150;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [DIM_W-1:0]  cfg_wdata;

  cif_in_if  in_ch();
  cif_out_if out_ch();

  filter_scoreboard sb;

  // Idling percentages of the current phase, and a request for one long sink hold-off
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;

  conv3x3_image_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit: far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("** conv3x3_image_filter: FAILED **");
    $finish;
  end

  // Sink: stall at random, or hold off for a long stretch when asked so that the
  // skid stage fills and the block has to stall its input.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Observe both channels at the clock edge: every input transfer feeds the
  // predictor, every output transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_pixel(in_ch.kind, in_ch.in_red, in_ch.in_green, in_ch.in_blue);
      if (out_ch.valid && out_ch.ready)
        sb.check_pixel('{out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                         out_ch.frame_last});
    end
  end

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offer one item, idling first at random; return at the edge of its transfer.
  // Valid stays high afterwards so that back-to-back items see no gap.
  task automatic send_pixel(input logic kind, input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.in_red   <= red;
    in_ch.in_green <= green;
    in_ch.in_blue  <= blue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // One whole frame: image pixels then the bottom border ticks. A few flush ticks land inside
  // the image, in odd_pct percent, and a few pixels inside the border, in twice that percent.
  task automatic send_frame(input int unsigned fw, input int unsigned fh,
                            input int unsigned odd_pct);
    for (int unsigned n = 0; n < fw * fh; n++)
      send_pixel($urandom_range(99) < odd_pct, rand_sample(), rand_sample(), rand_sample());
    for (int unsigned n = 0; n <= fw; n++)
      send_pixel(!($urandom_range(99) < 2 * odd_pct), rand_sample(), rand_sample(),
                 rand_sample());
  endtask

  // Drop valid, wait until every expected pixel has come, then let the pipeline
  // run dry: a transfer that completes no pixel may still be in flight.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write one register at the next edge; the caller lowers the enable afterwards
  task automatic write_reg(input cfg_idx_t idx, input logic [DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                           input logic [2:0] sel, input logic rgb,
                           output int unsigned fw, output int unsigned fh);
    write_reg(CFG_WIDTH, w_raw);
    write_reg(CFG_HEIGHT, h_raw);
    write_reg(CFG_FILTER, DIM_W'(sel));
    write_reg(CFG_COLOR, DIM_W'(rgb));
    cfg_we <= 1'b0;
    @(posedge clk);
    fw = clamp_dim(w_raw, MAX_WIDTH);
    fh = clamp_dim(h_raw, MAX_HEIGHT);
  endtask

  // Phases rotate through no idling, idle source, stalling sink, and both
  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // Mostly small sizes, now and then zero (reads as one) or a wider one
  function automatic logic [DIM_W-1:0] pick_dim(input int unsigned hi);
    case ($urandom_range(19))
      0:       return '0;
      1:       return DIM_W'($urandom_range(64, 20));
      default: return DIM_W'($urandom_range(hi, 1));
    endcase
  endfunction

  initial begin
    int unsigned fw, fh, random_items, phase_no;
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_WIDTH;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= 1'b0;
    in_ch.in_red   <= '0;
    in_ch.in_green <= '0;
    in_ch.in_blue  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: open a frame under the reset geometry (640 x 480, smooth, RGB),
    // then shrink it mid-row; the column counter stays inside the new width.
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'h00, 8'h80);
    settle();
    write_reg(CFG_WIDTH, 13'd4);
    write_reg(CFG_HEIGHT, 13'd2);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    // flush tick inside the image counts as a zero pixel
    send_pixel(1'b1, 8'd77, 8'd88, 8'd99);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'h80, 8'h01, 8'hFE);
    // bottom border, with one real pixel whose samples must be dropped
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    settle();

    // Zero geometry reads as 1 x 1; unused selector acts as smooth; gray mode
    configure('0, '0, SEL_UNUSED, 1'b0, fw, fh);
    send_pixel(1'b0, 8'd200, 8'd17, 8'd99);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    settle();

    // Oversize geometry reads as the maximum: open a frame at full width, then
    // shrink it so the column counter lies past the new width and moves down a row
    configure(13'd8191, 13'd8191, FILT_MEAN, 1'b1, fw, fh);
    repeat (20) send_pixel(1'b0, rand_sample(), rand_sample(), rand_sample());
    settle();
    configure(13'd5, 13'd3, FILT_EMBOSS, 1'b0, fw, fh);
    send_frame(fw, fh, 3);
    settle();

    // Back pressure: hold the sink off while the source keeps offering pixels
    configure(13'd8, 13'd4, FILT_SHARPEN, 1'b1, fw, fh);
    hold_request = 1'b1;
    send_frame(fw, fh, 0);
    send_frame(fw, fh, 5);
    settle();

    // Random phases: fresh settings, a few frames of random content each
    random_items = 0;
    phase_no     = 0;
    while (random_items < RANDOM_ITEMS) begin
      set_idling(phase_no);
      configure(pick_dim(12), pick_dim(6), 3'($urandom_range(7)), 1'($urandom_range(1)),
                fw, fh);
      repeat ($urandom_range(3, 1)) begin
        send_frame(fw, fh, 4);
        random_items += fw * fh + fw + 1;
      end
      settle();
      phase_no++;
    end

    sb.close_out();
    if (sb.errors == 0) begin
      $display("** conv3x3_image_filter: PASSED **");
    end else begin
      $display("** conv3x3_image_filter: FAILED **");
    end
    $finish;
  end

endmodule
